// ===== hdl/dceg_pkg.sv =====
// Shared types and constants of the damped complex exponential generator.
`default_nettype none

package dceg_pkg;

    // Configuration port geometry.
    localparam int unsigned REG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    // Register index, taken from the word address of the configuration port.
    typedef enum logic [2:0] {
        REG_STEP_REAL       = 3'd0,
        REG_STEP_IMAG       = 3'd1,
        REG_DERIVATIVE_MODE = 3'd2,
        REG_TIME_STEP       = 3'd3,
        REG_POINT_COUNT     = 3'd4
    } reg_idx_t;

    // Register values after reset.
    localparam logic [31:0] STEP_REAL_RST   = 32'h4000_0000;
    localparam logic [31:0] STEP_IMAG_RST   = 32'h0000_0000;
    localparam logic        DERIV_MODE_RST  = 1'b0;
    localparam logic [31:0] TIME_STEP_RST   = 32'h0001_0000;
    localparam logic [16:0] POINT_COUNT_RST = 17'd1024;

    // Request queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Register contents seen by the datapath.
    typedef struct packed {
        logic [31:0] step_real;
        logic [31:0] step_imag;
        logic        derivative_mode;
        logic [31:0] time_step;
        logic [16:0] point_count;
    } cfg_t;

    // Head of the request queue as the back sees it.
    typedef struct packed {
        logic valid;
        logic restart;
    } queue_head_t;

endpackage

`default_nettype wire

// ===== hdl/damped_complex_exponential_generator.sv =====
// Damped complex exponential generator: top level joining config, front and back.
//
// Usage: each request on the req channel (req_valid, req_stall, restart) yields
// exactly one point on the point channel (point_valid, point_stall, out_real,
// out_imag, point_index, last_point). restart = 1 begins a new block at point 0;
// a request after the last point of a block also begins a new block.
// The user must write registers through the APB-style port only while no request
// is in flight; the block does not enforce this. Points come from one shared
// sequencer with two 32x32 multipliers for the complex step and two 32-bit
// multipliers for the time weighting, whose 48-bit elapsed time is taken as the
// low 32 bits, then the high 16. A new block skips the complex step.
// A two-entry request queue lets requests arrive while the back end works, and
// the output register lets the next point be computed while one waits.
// When the receiver stalls, the point stays in the output register; the back end
// finishes its next point and then holds until the register frees, and the
// queue fills and stalls the requester after two more requests.
// Reset clears the queue and the output, restores register defaults, sets the
// phasor to 1.0, and makes the first request begin a block.
`default_nettype none

module damped_complex_exponential_generator #(
    parameter int unsigned MAX_POINTS       = 65536,
    parameter int unsigned SAMPLE_FRAC_BITS = 30
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire logic                               restart,
    output logic                                    point_valid,
    input  wire logic                               point_stall,
    output logic signed [63:0]                      out_real,
    output logic signed [63:0]                      out_imag,
    output logic        [15:0]                      point_index,
    output logic                                    last_point,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [dceg_pkg::REG_ADDR_W-1:0]    paddr,
    input  wire logic [dceg_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [dceg_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                    pready
);
    import dceg_pkg::*;

    cfg_t        cfg;
    queue_head_t head;
    logic        pop;

    // Register file.
    dceg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Request queue.
    dceg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .restart   (restart),
        .head      (head),
        .pop       (pop)
    );

    // Point computation and output register.
    dceg_back #(
        .MAX_POINTS       (MAX_POINTS),
        .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head        (head),
        .pop         (pop),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .out_real    (out_real),
        .out_imag    (out_imag),
        .point_index (point_index),
        .last_point  (last_point)
    );

endmodule

`default_nettype wire

// ===== hdl/dceg_cfg.sv =====
// Configuration register file with an APB-style access port.
`default_nettype none

module dceg_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [dceg_pkg::REG_ADDR_W-1:0]    paddr,
    input  wire logic [dceg_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [dceg_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                    pready,
    output dceg_pkg::cfg_t                          cfg
);
    import dceg_pkg::*;

    logic [31:0] step_real_reg;
    logic [31:0] step_imag_reg;
    logic        deriv_mode_reg;
    logic [31:0] time_step_reg;
    logic [16:0] point_count_reg;
    logic        wr_en;
    reg_idx_t    reg_idx;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[4:2]);

    // Register writes; addresses past the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_real_reg   <= STEP_REAL_RST;
            step_imag_reg   <= STEP_IMAG_RST;
            deriv_mode_reg  <= DERIV_MODE_RST;
            time_step_reg   <= TIME_STEP_RST;
            point_count_reg <= POINT_COUNT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_STEP_REAL:       step_real_reg   <= pwdata;
                REG_STEP_IMAG:       step_imag_reg   <= pwdata;
                REG_DERIVATIVE_MODE: deriv_mode_reg  <= pwdata[0];
                REG_TIME_STEP:       time_step_reg   <= pwdata;
                REG_POINT_COUNT:     point_count_reg <= pwdata[16:0];
                default:             ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (reg_idx)
            REG_STEP_REAL:       prdata = step_real_reg;
            REG_STEP_IMAG:       prdata = step_imag_reg;
            REG_DERIVATIVE_MODE: prdata = 32'(deriv_mode_reg);
            REG_TIME_STEP:       prdata = time_step_reg;
            REG_POINT_COUNT:     prdata = 32'(point_count_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.step_real       = step_real_reg;
    assign cfg.step_imag       = step_imag_reg;
    assign cfg.derivative_mode = deriv_mode_reg;
    assign cfg.time_step       = time_step_reg;
    assign cfg.point_count     = point_count_reg;

endmodule

`default_nettype wire

// ===== hdl/dceg_front.sv =====
// Front end: accepts requests and holds them in a short queue for the back end.
`default_nettype none

module dceg_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire logic                  restart,
    output dceg_pkg::queue_head_t      head,
    input  wire logic                  pop
);
    import dceg_pkg::*;

    logic              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              push;

    assign req_stall    = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign push         = req_valid && !req_stall;
    assign head.valid   = (fill_reg != '0);
    assign head.restart = slot_reg[rd_ptr_reg];

    // Queue storage; an entry is written on every accepted request.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= restart;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    // A request taken while nothing leaves raises the fill level by one.
    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("queue fill level did not follow a lone push");
`endif

endmodule

`default_nettype wire

// ===== hdl/dceg_back.sv =====
// Back end: phasor recursion, time weighting and the output register.
`default_nettype none

module dceg_back #(
    parameter int unsigned MAX_POINTS       = 65536,
    parameter int unsigned SAMPLE_FRAC_BITS = 30
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  dceg_pkg::cfg_t             cfg,
    input  dceg_pkg::queue_head_t      head,
    output logic                       pop,
    output logic                       point_valid,
    input  wire logic                  point_stall,
    output logic signed [63:0]         out_real,
    output logic signed [63:0]         out_imag,
    output logic        [15:0]         point_index,
    output logic                       last_point
);
    import dceg_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL2 = 8'b0000_0010,
        ST_RND  = 8'b0000_0100,
        ST_MAG  = 8'b0000_1000,
        ST_TLO  = 8'b0001_0000,
        ST_THI  = 8'b0010_0000,
        ST_SUM  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } back_state_t;

    localparam logic signed [31:0] PHASOR_ONE = 32'(64'd1 << SAMPLE_FRAC_BITS);
    localparam logic [63:0]        INT64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]        INT64_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0]        ROUND_HALF = 64'h0000_0000_0000_8000;

    // Round half up by the fraction width and saturate to 32 bits.
    function automatic logic signed [31:0] round_sat(input logic signed [64:0] sum);
        logic signed [63:0] s;
        logic signed [64:0] r1;
        logic signed [64:0] r2;
        logic signed [31:0] res;
        if (!sum[64] && sum[63])
        begin
            s = $signed(INT64_MAX);
        end
        else if (sum[64] && !sum[63])
        begin
            s = $signed(INT64_MIN);
        end
        else
        begin
            s = sum[63:0];
        end
        r1 = ($signed({s[63], s}) >>> (SAMPLE_FRAC_BITS - 1)) + 65'sd1;
        r2 = r1 >>> 1;
        if (r2 > 65'sd2147483647)
        begin
            res = 32'sh7FFF_FFFF;
        end
        else if (r2 < -65'sd2147483648)
        begin
            res = 32'sh8000_0000;
        end
        else
        begin
            res = r2[31:0];
        end
        return res;
    endfunction

    // Apply a sign to a rounded magnitude and saturate to 64 bits.
    function automatic logic [63:0] sign_sat(input logic [63:0] q, input logic neg);
        logic [63:0] res;
        if (!neg)
        begin
            res = q[63] ? INT64_MAX : q;
        end
        else
        begin
            res = q[63] ? INT64_MIN : (~q + 64'd1);
        end
        return res;
    endfunction

    back_state_t        state_reg, state_next;
    logic signed [31:0] phasor_real_reg, phasor_imag_reg;
    logic [16:0]        index_reg;
    logic [47:0]        elapsed_reg;
    logic signed [63:0] prod0_reg, prod1_reg, prod2_reg, prod3_reg;
    logic [31:0]        mag_y_reg, mag_x_reg;
    logic               neg_re_reg, neg_im_reg;
    logic [63:0]        plo_y_reg, plo_x_reg;
    logic [47:0]        phi_y_reg, phi_x_reg;
    logic [63:0]        q_y_reg, q_x_reg;
    logic               out_valid_reg;
    logic [63:0]        out_real_reg, out_imag_reg;
    logic [15:0]        out_index_reg;
    logic               out_last_reg;

    logic [31:0]        count_ext, count_eff;
    logic [16:0]        last_idx;
    logic               start_new;
    logic               new_blk;
    logic               load_out;
    logic signed [31:0] mul0_b, mul1_b;
    logic signed [63:0] mul0, mul1;
    logic [31:0]        t_sel;
    logic [63:0]        tmul_y, tmul_x;

    // Block length after clamping to the legal range.
    always_comb
    begin
        count_ext = 32'(cfg.point_count);
        if (count_ext == '0)
        begin
            count_eff = 32'd1;
        end
        else if (count_ext > 32'(MAX_POINTS))
        begin
            count_eff = 32'(MAX_POINTS);
        end
        else
        begin
            count_eff = count_ext;
        end
        last_idx = 17'(count_eff - 32'd1);
    end

    assign start_new = head.restart || (index_reg >= last_idx);
    assign pop       = (state_reg == ST_IDLE) && head.valid;
    assign new_blk   = pop && start_new;
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || !point_stall);

    // Two shared signed multipliers for the complex step.
    always_comb
    begin
        if (state_reg == ST_MUL2)
        begin
            mul0_b = $signed(cfg.step_imag);
            mul1_b = $signed(cfg.step_real);
        end
        else
        begin
            mul0_b = $signed(cfg.step_real);
            mul1_b = $signed(cfg.step_imag);
        end
    end
    assign mul0 = phasor_real_reg * mul0_b;
    assign mul1 = phasor_imag_reg * mul1_b;

    // Time weighting uses the low 32 bits of elapsed time first, then the high 16.
    assign t_sel  = (state_reg == ST_TLO) ? elapsed_reg[31:0] : 32'(elapsed_reg[47:32]);
    assign tmul_y = mag_y_reg * t_sel;
    assign tmul_x = mag_x_reg * t_sel;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    if (!start_new)
                    begin
                        state_next = ST_MUL2;
                    end
                    else
                    begin
                        state_next = cfg.derivative_mode ? ST_MAG : ST_OUT;
                    end
                end
            end
            ST_MUL2: state_next = ST_RND;
            ST_RND:  state_next = cfg.derivative_mode ? ST_MAG : ST_OUT;
            ST_MAG:  state_next = ST_TLO;
            ST_TLO:  state_next = ST_THI;
            ST_THI:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and the recursion state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phasor_real_reg <= PHASOR_ONE;
            phasor_imag_reg <= '0;
            index_reg       <= '1;
            elapsed_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (new_blk)
            begin
                phasor_real_reg <= PHASOR_ONE;
                phasor_imag_reg <= '0;
                index_reg       <= '0;
                elapsed_reg     <= '0;
            end
            if (state_reg == ST_MUL2)
            begin
                phasor_real_reg <= round_sat($signed({prod0_reg[63], prod0_reg})
                                           - $signed({prod1_reg[63], prod1_reg}));
            end
            if (state_reg == ST_RND)
            begin
                phasor_imag_reg <= round_sat($signed({prod2_reg[63], prod2_reg})
                                           + $signed({prod3_reg[63], prod3_reg}));
                index_reg       <= index_reg + 17'd1;
                elapsed_reg     <= elapsed_reg + 48'(cfg.time_step);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!point_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            prod0_reg <= mul0;
            prod1_reg <= mul1;
        end
        if (state_reg == ST_MUL2)
        begin
            prod2_reg <= mul0;
            prod3_reg <= mul1;
        end
        if (state_reg == ST_MAG)
        begin
            mag_y_reg  <= phasor_imag_reg[31] ? 32'(-phasor_imag_reg) : phasor_imag_reg;
            mag_x_reg  <= phasor_real_reg[31] ? 32'(-phasor_real_reg) : phasor_real_reg;
            neg_re_reg <= phasor_imag_reg[31];
            neg_im_reg <= !phasor_real_reg[31] && (phasor_real_reg != '0);
        end
        if (state_reg == ST_TLO)
        begin
            plo_y_reg <= tmul_y;
            plo_x_reg <= tmul_x;
        end
        if (state_reg == ST_THI)
        begin
            phi_y_reg <= tmul_y[47:0];
            phi_x_reg <= tmul_x[47:0];
            plo_y_reg <= plo_y_reg + ROUND_HALF;
            plo_x_reg <= plo_x_reg + ROUND_HALF;
        end
        if (state_reg == ST_SUM)
        begin
            q_y_reg <= {phi_y_reg, 16'd0} + {16'd0, plo_y_reg[63:16]};
            q_x_reg <= {phi_x_reg, 16'd0} + {16'd0, plo_x_reg[63:16]};
        end
        if (load_out)
        begin
            if (cfg.derivative_mode)
            begin
                out_real_reg <= sign_sat(q_y_reg, neg_re_reg);
                out_imag_reg <= sign_sat(q_x_reg, neg_im_reg);
            end
            else
            begin
                out_real_reg <= 64'(phasor_real_reg);
                out_imag_reg <= 64'(phasor_imag_reg);
            end
            out_index_reg <= index_reg[15:0];
            out_last_reg  <= (index_reg >= last_idx);
        end
    end

    assign point_valid = out_valid_reg;
    assign out_real    = out_real_reg;
    assign out_imag    = out_imag_reg;
    assign point_index = out_index_reg;
    assign last_point  = out_last_reg;

`ifndef SYNTHESIS
    // A new block starts from unit phasor, index zero and zero elapsed time.
    a_new_block: assert property (@(posedge clk) disable iff (!rst_n)
        new_blk |=> (index_reg == '0) && (phasor_real_reg == PHASOR_ONE)
                    && (phasor_imag_reg == '0) && (elapsed_reg == '0))
        else $error("new block did not reset the recursion state");

    // Elapsed time moves only on a recursion step or at a new block.
    a_elapsed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RND) && !new_blk |=> $stable(elapsed_reg))
        else $error("elapsed time changed outside a step");

    // After a point is taken, the output shows a point only if one was just loaded.
    a_out_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall |=> !point_valid || $past(state_reg == ST_OUT))
        else $error("output point repeated");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/damped_complex_exponential_generator_tb.sv =====
// Self-checking testbench of the damped complex exponential generator.
`default_nettype none

module damped_complex_exponential_generator_tb;
    import dceg_pkg::*;

    localparam int unsigned FRAC         = 30;
    localparam int unsigned MAX_POINTS   = 65536;
    localparam int          RANDOM_ITEMS = 1550;
    localparam int          LIMIT_CYCLES = 600000;
    localparam longint      I64_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint      I64_MIN      = -I64_MAX - 1;
    localparam logic [63:0] ONE          = 64'h0000_0000_4000_0000;

    // One point as the block presents it.
    typedef struct packed {
        logic [63:0] re;
        logic [63:0] im;
        logic [15:0] idx;
        logic        last_pt;
    } point_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    // One row of the directed sequence: a register write or a request.
    typedef struct packed {
        row_kind_t   kind;
        reg_idx_t    reg_sel;
        logic [31:0] value;
        logic        rs;
        logic        typed;
        point_t      want;
    } row_t;

    localparam logic [31:0] STEP_EDGES [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                              32'h4000_0000, 32'hC000_0000};

    // Directed sequence; rows with typed set carry their point, the rest are predicted.
    localparam row_t DIRECTED [32] = '{
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b1, '{ONE, 64'd0, 16'd0, 1'b0}},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b1, '{ONE, 64'd0, 16'd1, 1'b0}},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b1, 1'b1, '{ONE, 64'd0, 16'd0, 1'b0}},
        '{ROW_CFG, REG_POINT_COUNT,     32'd3,        1'b0, 1'b0, '0},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b1, '{ONE, 64'd0, 16'd1, 1'b0}},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b1, '{ONE, 64'd0, 16'd2, 1'b1}},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b1, '{ONE, 64'd0, 16'd0, 1'b0}},
        '{ROW_CFG, REG_POINT_COUNT,     32'd0,        1'b0, 1'b0, '0},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b1, '{ONE, 64'd0, 16'd0, 1'b1}},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b1, '{ONE, 64'd0, 16'd0, 1'b1}},
        '{ROW_CFG, REG_POINT_COUNT,     32'h1FFFF,    1'b0, 1'b0, '0},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b1, 1'b1, '{ONE, 64'd0, 16'd0, 1'b0}},
        '{ROW_CFG, REG_STEP_REAL,       32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_STEP_IMAG,       32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b0, '0},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b0, '0},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b0, '0},
        '{ROW_CFG, REG_STEP_REAL,       32'h8000_0000, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_STEP_IMAG,       32'h8000_0000, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b0, '0},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b0, '0},
        '{ROW_CFG, REG_DERIVATIVE_MODE, 32'd1,        1'b0, 1'b0, '0},
        '{ROW_CFG, REG_TIME_STEP,       32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b0, '0},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b0, '0},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b1, 1'b1, '{64'd0, 64'd0, 16'd0, 1'b0}},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b0, '0},
        '{ROW_CFG, REG_TIME_STEP,       32'd0,        1'b0, 1'b0, '0},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b0, '0},
        '{ROW_CFG, REG_POINT_COUNT,     32'd2,        1'b0, 1'b0, '0},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b1, '{64'd0, 64'd0, 16'd0, 1'b0}},
        '{ROW_REQ, REG_STEP_REAL,       32'd0,        1'b0, 1'b0, '0}
    };

    // Block ports; every input starts at a known value.
    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   req_valid   = 1'b0;
    logic                   req_stall;
    logic                   restart     = 1'b0;
    logic                   point_valid;
    logic                   point_stall = 1'b0;
    logic signed [63:0]     out_real;
    logic signed [63:0]     out_imag;
    logic [15:0]            point_index;
    logic                   last_point;
    logic                   psel        = 1'b0;
    logic                   penable     = 1'b0;
    logic                   pwrite      = 1'b0;
    logic [REG_ADDR_W-1:0]  paddr       = '0;
    logic [CFG_DATA_W-1:0]  pwdata      = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    // Register copies held by the predictor.
    logic [31:0] gen_step_re = STEP_REAL_RST;
    logic [31:0] gen_step_im = STEP_IMAG_RST;
    logic        gen_deriv   = DERIV_MODE_RST;
    logic [31:0] gen_dt      = TIME_STEP_RST;
    logic [16:0] gen_count   = POINT_COUNT_RST;

    // Generator state held by the predictor.
    longint      phasor_re   = longint'(ONE);
    longint      phasor_im   = 0;
    logic [16:0] blk_index   = 17'h1FFFF;
    logic [47:0] elapsed_t   = '0;

    point_t expected_points [$];
    int     fail_count  = 0;
    int     cycle_count = 0;
    bit     tx_quiet    = 1'b0;
    bit     rx_quiet    = 1'b0;

    damped_complex_exponential_generator dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Saturate a 66-bit product sum to 64 bits, round half up by FRAC and clamp to 32 bits.
    function automatic longint round_to_q(logic signed [65:0] s);
        longint v;
        longint r;
        if (s > 66'sh7FFF_FFFF_FFFF_FFFF)
            v = I64_MAX;
        else if (s < -66'sh8000_0000_0000_0000)
            v = I64_MIN;
        else
            v = longint'(s);
        r = ((v >>> (FRAC - 1)) + 1) >>> 1;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r;
    endfunction

    // Weight a phasor component by elapsed time (Q.16), round half away from zero.
    function automatic longint time_weight(longint v, bit negate, logic [47:0] t);
        logic [31:0] mag;
        logic [79:0] p;
        logic [63:0] q;
        mag = (v < 0) ? 32'(-v) : 32'(v);
        p = 80'(mag) * 80'(t) + 80'h8000;
        q = p[79:16];
        if (!negate)
            return q[63] ? I64_MAX : longint'(q);
        if (q[63])
            return I64_MIN;
        return -longint'(q);
    endfunction

    // Advance the generator by one request and return the point it yields.
    function automatic point_t next_point(logic rs);
        logic [16:0]        cnt;
        logic [16:0]        last_idx;
        longint             c;
        longint             d;
        logic signed [65:0] sum_re;
        logic signed [65:0] sum_im;
        point_t             p;
        cnt = gen_count;
        if (cnt == 0)
            cnt = 17'd1;
        if (cnt > MAX_POINTS)
            cnt = 17'(MAX_POINTS);
        last_idx = cnt - 17'd1;
        if (rs || blk_index >= last_idx)
        begin
            blk_index = '0;
            phasor_re = longint'(ONE);
            phasor_im = 0;
            elapsed_t = '0;
        end
        else
        begin
            c = longint'($signed(gen_step_re));
            d = longint'($signed(gen_step_im));
            sum_re = phasor_re * c - phasor_im * d;
            sum_im = phasor_re * d + phasor_im * c;
            phasor_re = round_to_q(sum_re);
            phasor_im = round_to_q(sum_im);
            blk_index = blk_index + 17'd1;
            elapsed_t = elapsed_t + 48'(gen_dt);
        end
        // Derivative mode gives -i*t*E = t*y - i*t*x.
        if (gen_deriv)
        begin
            p.re = time_weight(phasor_im, phasor_im < 0, elapsed_t);
            p.im = time_weight(phasor_re, phasor_re > 0, elapsed_t);
        end
        else
        begin
            p.re = phasor_re;
            p.im = phasor_im;
        end
        p.idx = blk_index[15:0];
        p.last_pt = (blk_index >= last_idx);
        return p;
    endfunction

    // Offer one request after a random gap and log its point once accepted.
    task automatic send_request(logic rs, bit typed, point_t want);
        int     gap;
        point_t p;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        restart <= rs;
        do @(posedge clk); while (req_stall);
        p = next_point(rs);
        expected_points.push_back(typed ? want : p);
    endtask

    // Stop requesting and wait until every outstanding point has arrived.
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(reg_idx_t sel, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (sel)
            REG_STEP_REAL:       gen_step_re = val;
            REG_STEP_IMAG:       gen_step_im = val;
            REG_DERIVATIVE_MODE: gen_deriv = val[0];
            REG_TIME_STEP:       gen_dt = val;
            REG_POINT_COUNT:     gen_count = val[16:0];
            default:             ;
        endcase
    endtask

    // Draw a full register setting, mixing typical, decaying and extreme values.
    task automatic write_random_config();
        logic [31:0] re;
        logic [31:0] im;
        logic [31:0] dt;
        logic [16:0] cnt;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                re = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
                im = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
            end
            5, 6:
            begin
                re = 32'h4000_0000 - $urandom_range(0, 32'h0100_0000);
                im = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            end
            7:
            begin
                re = $urandom;
                im = $urandom;
            end
            default:
            begin
                re = STEP_EDGES[$urandom_range(0, 4)];
                im = STEP_EDGES[$urandom_range(0, 4)];
            end
        endcase
        case ($urandom_range(0, 5))
            0:       dt = 32'd0;
            1:       dt = 32'hFFFF_FFFF;
            2:       dt = $urandom;
            default: dt = $urandom_range(0, 32'h0004_0000);
        endcase
        case ($urandom_range(0, 9))
            0:       cnt = 17'd0;
            1:       cnt = 17'd65536;
            2:       cnt = 17'h1FFFF;
            3:       cnt = 17'($urandom);
            4:       cnt = 17'd1;
            default: cnt = 17'($urandom_range(2, 40));
        endcase
        write_reg(REG_STEP_REAL, re);
        write_reg(REG_STEP_IMAG, im);
        write_reg(REG_DERIVATIVE_MODE, 32'($urandom_range(0, 1)));
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_POINT_COUNT, 32'(cnt));
    endtask

    // Point receiver: stalls for a random number of cycles before each point.
    initial
    begin : point_sink
        int hold;
        forever
        begin
            hold = rx_quiet ? 0 : $urandom_range(0, 10);
            if (hold != 0)
            begin
                @(negedge clk);
                point_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            point_stall <= 1'b0;
            do @(posedge clk); while (!(point_valid && !point_stall));
            if ($urandom_range(0, 39) == 0)
                rx_quiet = !rx_quiet;
        end
    end

    // Compare each accepted point with the oldest outstanding one.
    always @(posedge clk)
    begin : point_check
        point_t want;
        if (rst_n && point_valid && !point_stall)
        begin
            if (expected_points.size() == 0)
            begin
                $error("point with no request pending, index %0d", point_index);
                fail_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (out_real !== want.re)
                begin
                    $error("out_real: expected %0d, got %0d", $signed(want.re), out_real);
                    fail_count++;
                end
                if (out_imag !== want.im)
                begin
                    $error("out_imag: expected %0d, got %0d", $signed(want.im), out_imag);
                    fail_count++;
                end
                if (point_index !== want.idx)
                begin
                    $error("point_index: expected %0d, got %0d", want.idx, point_index);
                    fail_count++;
                end
                if (last_point !== want.last_pt)
                begin
                    $error("last_point: expected %0d, got %0d", want.last_pt, last_point);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("FAIL damped_complex_exponential_generator");
            $finish;
        end
    end

    // Reset, directed rows, then random phases, each under a fresh register setting.
    initial
    begin : stimulus
        int sent;
        int len;
        sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(DIRECTED[i].reg_sel, DIRECTED[i].value);
            end
            else
                send_request(DIRECTED[i].rs, DIRECTED[i].typed, DIRECTED[i].want);
        end

        while (sent < RANDOM_ITEMS)
        begin
            drain();
            write_random_config();
            tx_quiet = ($urandom_range(0, 3) == 0);
            len = $urandom_range(40, 120);
            repeat (len)
            begin
                send_request($urandom_range(0, 11) == 0, 1'b0, '0);
                sent++;
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_points.size() == 0)
            $display("PASS damped_complex_exponential_generator");
        else
            $display("FAIL damped_complex_exponential_generator");
        $finish;
    end

endmodule

`default_nettype wire
